### sv/ctlv_pkg.sv
// ctlv_pkg: types and constants shared by the compact tlv item decoder
// no dependencies; compile first
package ctlv_pkg;

    // decoder phase, what the next byte means
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_INT    = 2'd1,
        PH_STR    = 2'd2
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        KIND_STR_HDR  = 3'd0,
        KIND_STR_BYTE = 3'd1,
        KIND_POS      = 3'd2,
        KIND_NEG      = 3'd3,
        KIND_SMALL    = 3'd4
    } t_kind;

    // header type field, bits 7:6
    localparam logic [1:0] TYPE_STR   = 2'b00;
    localparam logic [1:0] TYPE_POS   = 2'b01;
    localparam logic [1:0] TYPE_NEG   = 2'b10;
    localparam logic [1:0] TYPE_SMALL = 2'b11;

    // integer size field, bits 5:4
    localparam logic [1:0] SIZE_1 = 2'b00;
    localparam logic [1:0] SIZE_2 = 2'b01;
    localparam logic [1:0] SIZE_3 = 2'b10;
    localparam logic [1:0] SIZE_5 = 2'b11;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEFT_W  = 6;

endpackage

### sv/ctlv_if.sv
// ctlv_in_if / ctlv_out_if: valid/ready channels of the tlv item decoder
// depends on ctlv_pkg
interface ctlv_in_if;
    logic                              valid;
    logic                              ready;
    logic [ctlv_pkg::BYTE_W-1:0]       byte_in;
    logic                              frame_start;

    modport source (output valid, output byte_in, output frame_start, input ready);
    modport sink   (input valid, input byte_in, input frame_start, output ready);
endinterface

interface ctlv_out_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        kind;
    logic signed [ctlv_pkg::VALUE_W-1:0] value;
    logic                              last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

### sv/compact_tlv_item_decoder_core.sv
// compact_tlv_item_decoder_core: byte-serial decoder for compact tagged items
// depends on ctlv_pkg and the channel interfaces in ctlv_if.sv
//
// usage
//   i_in takes one encoded word (byte_in, frame_start) per handshake.
//   o_out gives at most one result word (kind, value, last) per input word:
//   a small value, a complete integer, a string header, or one string byte.
//   multi-byte integer header and middle bytes give no result; the integer comes out
//   with its final byte. frame_start drops any partial item and decodes the
//   word as a header.
// timing
//   one word per cycle sustained while o_out.ready is high. a word goes
//   through a two-register path on its way to the output: input
//   register, decode logic, result register. the decode is one byte-wide
//   header decode or one shift-and-or into the accumulator per word.
// reset
//   i_rst_n low at a clock edge empties both registers and returns the
//   decoder to expecting a header with a cleared accumulator.
// stall
//   when o_out.ready is low the result register holds; the input register
//   keeps advancing while its word makes no result, then holds, and
//   i_in.ready drops once both are full. nothing is lost or repeated.
module compact_tlv_item_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctlv_in_if.sink       i_in,
    ctlv_out_if.source    o_out
);

    // input register
    logic                              r_in_valid;
    logic [ctlv_pkg::BYTE_W-1:0]       r_in_byte;
    logic                              r_in_fs;

    // decoder state
    ctlv_pkg::t_phase                  r_phase,   n_phase;
    logic [ctlv_pkg::LEFT_W-1:0]       r_left,    n_left;
    logic                              r_neg,     n_neg;
    logic [ctlv_pkg::VALUE_W-1:0]      r_acc,     n_acc;

    // result register
    logic                              r_out_valid;
    ctlv_pkg::t_kind                   r_kind,    n_kind;
    logic [ctlv_pkg::VALUE_W-1:0]      r_value,   n_value;
    logic                              r_last,    n_last;

    logic                              emit;
    logic                              out_free;
    logic                              advance;
    ctlv_pkg::t_phase                  eff_phase;
    logic [1:0]                        hdr_type;
    logic [1:0]                        hdr_size;
    logic [ctlv_pkg::VALUE_W-1:0]      shifted;
    logic [ctlv_pkg::LEFT_W-1:0]       left_dec;

    // handshake: the decode stage moves when its result has somewhere to go
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    assign hdr_type = r_in_byte[7:6];
    assign hdr_size = r_in_byte[5:4];
    assign shifted  = {r_acc[ctlv_pkg::VALUE_W-ctlv_pkg::BYTE_W-1:0], r_in_byte};
    assign left_dec = r_left - ctlv_pkg::LEFT_W'(1);

    // frame start forces a header decode
    assign eff_phase = r_in_fs ? ctlv_pkg::PH_HEADER : r_phase;

    always_comb begin
        n_phase = eff_phase;
        n_left  = r_left;
        n_neg   = r_neg;
        n_acc   = r_acc;
        emit    = 1'b0;
        n_kind  = ctlv_pkg::KIND_SMALL;
        n_value = '0;
        n_last  = 1'b1;
        case (eff_phase)
            ctlv_pkg::PH_INT: begin
                // collect one more big-endian byte
                n_acc  = shifted;
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = ctlv_pkg::PH_HEADER;
                    emit    = 1'b1;
                    n_kind  = r_neg ? ctlv_pkg::KIND_NEG : ctlv_pkg::KIND_POS;
                    n_value = r_neg ? ~shifted : shifted;
                end
            end
            ctlv_pkg::PH_STR: begin
                // pass payload byte, final one when one or none is owed
                emit    = 1'b1;
                n_kind  = ctlv_pkg::KIND_STR_BYTE;
                n_value = {{(ctlv_pkg::VALUE_W-ctlv_pkg::BYTE_W){1'b0}}, r_in_byte};
                n_last  = (r_left <= ctlv_pkg::LEFT_W'(1));
                if (n_last) begin
                    n_left  = '0;
                    n_phase = ctlv_pkg::PH_HEADER;
                end else begin
                    n_left = left_dec;
                end
            end
            default: begin
                // header byte; the unused phase code lands here too
                case (hdr_type)
                    ctlv_pkg::TYPE_SMALL: begin
                        n_phase = ctlv_pkg::PH_HEADER;
                        emit    = 1'b1;
                        n_kind  = ctlv_pkg::KIND_SMALL;
                        n_value = {{(ctlv_pkg::VALUE_W-6){1'b0}}, r_in_byte[5:0]};
                    end
                    ctlv_pkg::TYPE_STR: begin
                        n_left  = r_in_byte[5:0];
                        n_phase = (r_in_byte[5:0] != '0) ? ctlv_pkg::PH_STR
                                                         : ctlv_pkg::PH_HEADER;
                        emit    = 1'b1;
                        n_kind  = ctlv_pkg::KIND_STR_HDR;
                        n_value = {{(ctlv_pkg::VALUE_W-6){1'b0}}, r_in_byte[5:0]};
                        n_last  = (r_in_byte[5:0] == '0);
                    end
                    default: begin
                        // integer: header nibble seeds the accumulator
                        n_neg = (hdr_type == ctlv_pkg::TYPE_NEG);
                        n_acc = {{(ctlv_pkg::VALUE_W-4){1'b0}}, r_in_byte[3:0]};
                        case (hdr_size)
                            ctlv_pkg::SIZE_1: begin
                                n_phase = ctlv_pkg::PH_HEADER;
                                n_left  = '0;
                                emit    = 1'b1;
                                n_kind  = n_neg ? ctlv_pkg::KIND_NEG : ctlv_pkg::KIND_POS;
                                n_value = n_neg ? ~n_acc : n_acc;
                            end
                            ctlv_pkg::SIZE_2: begin
                                n_phase = ctlv_pkg::PH_INT;
                                n_left  = ctlv_pkg::LEFT_W'(1);
                            end
                            ctlv_pkg::SIZE_3: begin
                                n_phase = ctlv_pkg::PH_INT;
                                n_left  = ctlv_pkg::LEFT_W'(2);
                            end
                            default: begin
                                n_phase = ctlv_pkg::PH_INT;
                                n_left  = ctlv_pkg::LEFT_W'(4);
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= ctlv_pkg::PH_HEADER;
            r_left      <= '0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.byte_in;
            r_in_fs   <= i_in.frame_start;
        end
        if (advance && emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_kind;
    assign o_out.value = r_value;
    assign o_out.last  = r_last;

endmodule
